FILE: design/cvl_pkg.sv
// ----------------------------------------------------------------------------
// cvl_pkg
// Shared types and constants for the compacting value list: request codes,
// controller states and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package cvl_pkg;

    // default number of list positions
    localparam int CVL_CAPACITY_DEF = 16;

    // request codes
    typedef enum logic [1:0] {
        OP_INS_FRONT = 2'd0,
        OP_INS_BACK  = 2'd1,
        OP_REMOVE    = 2'd2,
        OP_SEARCH    = 2'd3
    } req_op_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FRONT_RD,
        ST_FRONT_WR,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR
    } cvl_state_t;

    // read address source, relative to the position index
    typedef enum logic [1:0] {
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_P1
    } rd_sel_t;

    // write data source
    typedef enum logic {
        WD_VALUE,
        WD_RDATA
    } wd_sel_t;

    // controller to datapath
    typedef struct packed {
        logic    in_ready;
        logic    idx_from_count;
        logic    idx_inc;
        logic    idx_dec;
        rd_sel_t rd_sel;
        logic    ram_we;
        wd_sel_t wd_sel;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_ok;
        logic    rsp_load;
    } cvl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic    in_valid;
        req_op_t op;
        logic    empty;
        logic    full;
        logic    idx_zero;
        logic    idx_last;
        logic    hit;
        logic    rsp_free;
    } cvl_sts_t;

endpackage

FILE: design/cvl_req_if.sv
// ----------------------------------------------------------------------------
// cvl_req_if
// Request channel: one word carries a request code and a signed value.
// ----------------------------------------------------------------------------
interface cvl_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [31:0] item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

FILE: design/cvl_rsp_if.sv
// ----------------------------------------------------------------------------
// cvl_rsp_if
// Response channel: one word per request with status and list occupancy.
// ----------------------------------------------------------------------------
interface cvl_rsp_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [4:0] entry_count;
    logic       is_empty;
    logic       is_full;

    modport source (output valid, output ok, output entry_count, output is_empty,
                    output is_full, input ready);
    modport sink   (input valid, input ok, input entry_count, input is_empty,
                    input is_full, output ready);
endinterface

FILE: design/cvl_ram.sv
// ----------------------------------------------------------------------------
// cvl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cvl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: design/cvl_ctrl.sv
// ----------------------------------------------------------------------------
// cvl_ctrl
// Sequencer for the list: dispatches a request, walks the storage for shifts
// and scans, and hands the finished result to the response register.
// ----------------------------------------------------------------------------
module cvl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  cvl_pkg::cvl_sts_t sts,
    output cvl_pkg::cvl_cmd_t cmd
);
    import cvl_pkg::*;

    cvl_state_t state_reg;
    cvl_state_t state_next;
    logic       rsp_pending_reg;
    logic       rsp_pending_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rsp_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rsp_pending_reg <= rsp_pending_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next       = state_reg;
        rsp_pending_next = rsp_pending_reg;
        cmd              = '0;
        cmd.rd_sel       = RD_IDX;
        cmd.wd_sel       = WD_VALUE;

        unique case (state_reg)
            ST_IDLE:
            begin
                // a finished result waits here until the response register frees
                if (rsp_pending_reg)
                begin
                    if (sts.rsp_free)
                    begin
                        cmd.rsp_load     = 1'b1;
                        rsp_pending_next = 1'b0;
                    end
                end
                else
                begin
                    cmd.in_ready       = 1'b1;
                    cmd.idx_from_count = (sts.op == OP_INS_FRONT) || (sts.op == OP_INS_BACK);
                    if (sts.in_valid)
                    begin
                        state_next = ST_DISPATCH;
                    end
                end
            end

            ST_DISPATCH:
            begin
                unique case (sts.op)
                    OP_INS_BACK:
                    begin
                        if (!sts.full)
                        begin
                            cmd.ram_we  = 1'b1;
                            cmd.wd_sel  = WD_VALUE;
                            cmd.cnt_inc = 1'b1;
                            cmd.set_ok  = 1'b1;
                        end
                        rsp_pending_next = 1'b1;
                        state_next       = ST_IDLE;
                    end
                    OP_INS_FRONT:
                    begin
                        if (sts.full)
                        begin
                            rsp_pending_next = 1'b1;
                            state_next       = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_FRONT_RD;
                        end
                    end
                    OP_REMOVE, OP_SEARCH:
                    begin
                        if (sts.empty)
                        begin
                            rsp_pending_next = 1'b1;
                            state_next       = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_SCAN_RD;
                        end
                    end
                endcase
            end

            // shift up from the top, then place the new word at position zero
            ST_FRONT_RD:
            begin
                if (sts.idx_zero)
                begin
                    cmd.ram_we       = 1'b1;
                    cmd.wd_sel       = WD_VALUE;
                    cmd.cnt_inc      = 1'b1;
                    cmd.set_ok       = 1'b1;
                    rsp_pending_next = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_IDX_M1;
                    state_next = ST_FRONT_WR;
                end
            end

            ST_FRONT_WR:
            begin
                cmd.ram_we  = 1'b1;
                cmd.wd_sel  = WD_RDATA;
                cmd.idx_dec = 1'b1;
                state_next  = ST_FRONT_RD;
            end

            // linear scan for the first equal word
            ST_SCAN_RD:
            begin
                cmd.rd_sel = RD_IDX;
                state_next = ST_SCAN_CMP;
            end

            ST_SCAN_CMP:
            begin
                if (sts.hit)
                begin
                    cmd.set_ok = 1'b1;
                    if (sts.op == OP_REMOVE)
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        rsp_pending_next = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end
                else if (sts.idx_last)
                begin
                    rsp_pending_next = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
            end

            // close the gap by moving later words down one place
            ST_SHIFT_RD:
            begin
                if (sts.idx_last)
                begin
                    cmd.cnt_dec      = 1'b1;
                    rsp_pending_next = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_IDX_P1;
                    state_next = ST_SHIFT_WR;
                end
            end

            ST_SHIFT_WR:
            begin
                cmd.ram_we  = 1'b1;
                cmd.wd_sel  = WD_RDATA;
                cmd.idx_inc = 1'b1;
                state_next  = ST_SHIFT_RD;
            end
        endcase
    end
endmodule

FILE: design/cvl_dpath.sv
// ----------------------------------------------------------------------------
// cvl_dpath
// Datapath of the list: request capture, count and position index, storage
// RAM, compare, and the response register.
// ----------------------------------------------------------------------------
module cvl_dpath #(
    parameter int CAPACITY = cvl_pkg::CVL_CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    cvl_req_if.sink           req,
    cvl_rsp_if.source         rsp,
    input  cvl_pkg::cvl_cmd_t cmd,
    output cvl_pkg::cvl_sts_t sts
);
    import cvl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] ONE   = CW'(1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    req_op_t            op_reg;
    logic signed [31:0] val_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      idx_reg;
    logic               ok_reg;
    logic               rsp_valid_reg;
    logic               rsp_ok_reg;
    logic [4:0]         rsp_count_reg;
    logic               rsp_empty_reg;
    logic               rsp_full_reg;

    logic               accept;
    logic [CW-1:0]      idx_m1;
    logic [CW-1:0]      idx_p1;
    logic [CW-1:0]      rd_idx;
    logic [31:0]        wdata;
    logic [31:0]        rdata;
    logic [CW+4:0]      count_ext;

    assign accept    = req.valid && cmd.in_ready;
    assign req.ready = cmd.in_ready;
    assign idx_m1    = idx_reg - ONE;
    assign idx_p1    = idx_reg + ONE;

    // request capture and position index
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req_op_t'(req.req_type);
            val_reg <= req.item_value;
            ok_reg  <= 1'b0;
            idx_reg <= cmd.idx_from_count ? count_reg : '0;
        end
        else
        begin
            if (cmd.set_ok)
            begin
                ok_reg <= 1'b1;
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_p1;
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_m1;
            end
        end
    end

    // stored word count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + ONE;
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // storage access
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_IDX:    rd_idx = idx_reg;
            RD_IDX_M1: rd_idx = idx_m1;
            RD_IDX_P1: rd_idx = idx_p1;
            default:   rd_idx = idx_reg;
        endcase
    end

    assign wdata = (cmd.wd_sel == WD_RDATA) ? rdata : val_reg;

    cvl_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.ram_we),
        .waddr (idx_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (rd_idx[AW-1:0]),
        .rdata (rdata)
    );

    // status to the controller
    always_comb
    begin
        sts.in_valid = req.valid;
        sts.op       = cmd.in_ready ? req_op_t'(req.req_type) : op_reg;
        sts.empty    = (count_reg == '0);
        sts.full     = (count_reg == CAP_C);
        sts.idx_zero = (idx_reg == '0);
        sts.idx_last = (idx_p1 == count_reg);
        sts.hit      = (rdata == val_reg);
        sts.rsp_free = !rsp_valid_reg || rsp.ready;
    end

    // response register
    assign count_ext = {5'b0, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rsp_load)
        begin
            rsp_ok_reg    <= ok_reg;
            rsp_count_reg <= count_ext[4:0];
            rsp_empty_reg <= (count_reg == '0);
            rsp_full_reg  <= (count_reg == CAP_C);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.ok          = rsp_ok_reg;
    assign rsp.entry_count = rsp_count_reg;
    assign rsp.is_empty    = rsp_empty_reg;
    assign rsp.is_full     = rsp_full_reg;
endmodule

FILE: design/compacting_value_list.sv
// Insert back writes the word directly; insert front moves the stored words up
// one place from the top, then writes position zero; search scans up from zero
// to the first match or the last word; remove then moves the later words down
// one place. Storage is a RAM with one write port and one registered read port.
// One request at a time; the next is taken once the result is registered.
// Reset empties the list (count cleared); storage contents are not cleared.
// ----------------------------------------------------------------------------
// compacting_value_list
// Bounded ordered list of signed 32-bit values packed from position zero,
// with insert front, insert back, remove first match and search.
// ----------------------------------------------------------------------------
module compacting_value_list #(
    parameter int CAPACITY = cvl_pkg::CVL_CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    cvl_req_if.sink   req,
    cvl_rsp_if.source rsp
);
    import cvl_pkg::*;

    cvl_cmd_t cmd;
    cvl_sts_t sts;

    // sequencer
    cvl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // storage, count and response register
    cvl_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );
endmodule
